// ===== rtl/rgbm_pkg.sv =====
// Shared types, constants and compare functions for the RGB 3x3 median filter.
package rgbm_pkg;

    localparam int PIX_W     = 8;
    localparam int WIN_ROWS  = 3;
    localparam int WIN_CELLS = WIN_ROWS * WIN_ROWS;

    typedef logic [PIX_W-1:0] t_pix;

    // Cells 0..2 are the newest column, 3..5 the previous one, 6..8 the oldest.
    typedef t_pix [WIN_CELLS-1:0] t_win;

    typedef struct packed {
        t_pix lo;
        t_pix mid;
        t_pix hi;
    } t_sort3;

    function automatic t_pix f_min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix f_max2(input t_pix a, input t_pix b);
        return (a < b) ? b : a;
    endfunction

    // Three compare-exchange steps sort three values.
    function automatic t_sort3 f_sort3(input t_pix a, input t_pix b, input t_pix c);
        t_pix   l1;
        t_pix   h1;
        t_pix   l2;
        t_sort3 s;
        l1    = f_min2(a, b);
        h1    = f_max2(a, b);
        s.hi  = f_max2(h1, c);
        l2    = f_min2(h1, c);
        s.lo  = f_min2(l1, l2);
        s.mid = f_max2(l1, l2);
        return s;
    endfunction

    function automatic t_pix f_max3(input t_pix a, input t_pix b, input t_pix c);
        return f_max2(f_max2(a, b), c);
    endfunction

    function automatic t_pix f_min3(input t_pix a, input t_pix b, input t_pix c);
        return f_min2(f_min2(a, b), c);
    endfunction

    function automatic t_pix f_med3(input t_pix a, input t_pix b, input t_pix c);
        return f_max2(f_min2(a, b), f_min2(f_max2(a, b), c));
    endfunction

endpackage

// ===== rtl/rgbm_window.sv =====
// Column history and window input register for one color channel.
module rgbm_window (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  rgbm_pkg::t_pix i_top,
    input  rgbm_pkg::t_pix i_mid,
    input  rgbm_pkg::t_pix i_bot,
    output rgbm_pkg::t_win o_win
);

    rgbm_pkg::t_pix r_prev_top, r_prev_mid, r_prev_bot;
    rgbm_pkg::t_pix r_old_top,  r_old_mid,  r_old_bot;
    rgbm_pkg::t_win r_win;

    // The two stored columns start at zero and shift by one column per transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_top <= '0;
            r_prev_mid <= '0;
            r_prev_bot <= '0;
            r_old_top  <= '0;
            r_old_mid  <= '0;
            r_old_bot  <= '0;
        end else if (i_load) begin
            r_old_top  <= r_prev_top;
            r_old_mid  <= r_prev_mid;
            r_old_bot  <= r_prev_bot;
            r_prev_top <= i_top;
            r_prev_mid <= i_mid;
            r_prev_bot <= i_bot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_win <= {r_old_bot, r_old_mid, r_old_top,
                      r_prev_bot, r_prev_mid, r_prev_top,
                      i_bot, i_mid, i_top};
        end
    end

    assign o_win = r_win;

endmodule

// ===== rtl/rgbm_median9.sv =====
// Compare network that picks the median of a nine-value window.
module rgbm_median9 (
    input  rgbm_pkg::t_win i_win,
    output rgbm_pkg::t_pix o_median
);

    rgbm_pkg::t_sort3 w_c0, w_c1, w_c2;
    rgbm_pkg::t_pix   w_lo_max, w_mid_med, w_hi_min;

    // Sort each column, then the median is the median of the max of the
    // lows, the median of the middles and the min of the highs.
    always_comb begin
        w_c0      = rgbm_pkg::f_sort3(i_win[0], i_win[1], i_win[2]);
        w_c1      = rgbm_pkg::f_sort3(i_win[3], i_win[4], i_win[5]);
        w_c2      = rgbm_pkg::f_sort3(i_win[6], i_win[7], i_win[8]);
        w_lo_max  = rgbm_pkg::f_max3(w_c0.lo, w_c1.lo, w_c2.lo);
        w_mid_med = rgbm_pkg::f_med3(w_c0.mid, w_c1.mid, w_c2.mid);
        w_hi_min  = rgbm_pkg::f_min3(w_c0.hi, w_c1.hi, w_c2.hi);
        o_median  = rgbm_pkg::f_med3(w_lo_max, w_mid_med, w_hi_min);
    end

endmodule

// ===== rtl/rgb_median_3x3_window_core.sv =====
// Top level of the RGB 3x3 sliding median filter.
//
//   Channel   Direction  Handshake            Payload
//   column    in         i_valid / o_ready    i_{red,green,blue}_{top,mid,bot}
//   median    out        o_valid / i_ready    o_median_{red,green,blue}
//
// A column is captured in the window register at the edge that accepts it, and its
// compare network result moves into the result register, which drives o_valid, once
// that register is free; a column is taken every cycle while the output is not stalled.
// Reset clears the two stored columns of every channel to zero and empties both
// stages; the first two results therefore include those zero columns.
// When the output stalls, both stages fill and o_ready drops; nothing is lost or repeated.
module rgb_median_3x3_window_core (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [7:0] i_red_top,
    input  logic [7:0] i_red_mid,
    input  logic [7:0] i_red_bot,
    input  logic [7:0] i_green_top,
    input  logic [7:0] i_green_mid,
    input  logic [7:0] i_green_bot,
    input  logic [7:0] i_blue_top,
    input  logic [7:0] i_blue_mid,
    input  logic [7:0] i_blue_bot,
    output logic o_valid,
    input  logic i_ready,
    output logic [7:0] o_median_red,
    output logic [7:0] o_median_green,
    output logic [7:0] o_median_blue
);

    logic r_win_valid;
    logic r_out_valid;
    logic w_out_free;
    logic w_win_free;
    logic w_in_accept;
    logic w_win_move;

    rgbm_pkg::t_win w_win_red, w_win_green, w_win_blue;
    rgbm_pkg::t_pix w_med_red, w_med_green, w_med_blue;
    rgbm_pkg::t_pix r_med_red, r_med_green, r_med_blue;

    // The result register can load when empty or when its result leaves now.
    // The window register can load when empty or when it hands on now.
    always_comb begin
        w_out_free  = !r_out_valid || i_ready;
        w_win_move  = r_win_valid && w_out_free;
        w_win_free  = !r_win_valid || w_out_free;
        w_in_accept = i_valid && w_win_free;
    end

    assign o_ready = w_win_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_win_free) begin
                r_win_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_win_valid;
            end
        end
    end

    // The medians of the window stage move into the result register together.
    always_ff @(posedge i_clk) begin
        if (w_win_move) begin
            r_med_red   <= w_med_red;
            r_med_green <= w_med_green;
            r_med_blue  <= w_med_blue;
        end
    end

    rgbm_window u_win_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_in_accept),
        .i_top   (i_red_top),
        .i_mid   (i_red_mid),
        .i_bot   (i_red_bot),
        .o_win   (w_win_red)
    );

    rgbm_window u_win_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_in_accept),
        .i_top   (i_green_top),
        .i_mid   (i_green_mid),
        .i_bot   (i_green_bot),
        .o_win   (w_win_green)
    );

    rgbm_window u_win_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_in_accept),
        .i_top   (i_blue_top),
        .i_mid   (i_blue_mid),
        .i_bot   (i_blue_bot),
        .o_win   (w_win_blue)
    );

    rgbm_median9 u_med_red (
        .i_win    (w_win_red),
        .o_median (w_med_red)
    );

    rgbm_median9 u_med_green (
        .i_win    (w_win_green),
        .o_median (w_med_green)
    );

    rgbm_median9 u_med_blue (
        .i_win    (w_win_blue),
        .o_median (w_med_blue)
    );

    assign o_valid        = r_out_valid;
    assign o_median_red   = r_med_red;
    assign o_median_green = r_med_green;
    assign o_median_blue  = r_med_blue;

    // An accepted column always occupies the window stage in the next cycle.
    a_in_to_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_win_valid)
        else $error("accepted column did not reach the window stage");

    // A window that moves on always produces a pending result.
    a_win_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_win_move |=> r_out_valid)
        else $error("window moved on without producing a result");

    // Back pressure only when both stages are full and the result is stalled.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_win_valid && r_out_valid && !i_ready))
        else $error("input stalled while the pipeline had room");

endmodule

// ===== tb/rgb_median_3x3_window_core_test.sv =====
// Self-checking testbench for the RGB 3x3 sliding median filter core.
module rgb_median_3x3_window_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef rgbm_pkg::t_pix t_pix;

    // Column and result layouts, one field per port of the block.
    typedef struct packed {
        t_pix red_top;
        t_pix red_mid;
        t_pix red_bot;
        t_pix green_top;
        t_pix green_mid;
        t_pix green_bot;
        t_pix blue_top;
        t_pix blue_mid;
        t_pix blue_bot;
    } t_column;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
    } t_median;

    // Ways of drawing the pixels of a random column.
    typedef enum int {
        MIX_UNIFORM,
        MIX_CLUSTER,
        MIX_EXTREME,
        MIX_FLAT
    } t_pix_mix;

    localparam int RANDOM_COLUMNS = 1630;
    localparam int QUIET_TAIL     = 150;   // columns left when idling stops
    localparam int HOLD_AT        = 400;   // results seen before the long output stall
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 3000;

    // Clock, reset and block ports.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic i_valid = 1'b0;
    logic o_ready;
    logic [7:0] i_red_top   = '0;
    logic [7:0] i_red_mid   = '0;
    logic [7:0] i_red_bot   = '0;
    logic [7:0] i_green_top = '0;
    logic [7:0] i_green_mid = '0;
    logic [7:0] i_green_bot = '0;
    logic [7:0] i_blue_top  = '0;
    logic [7:0] i_blue_mid  = '0;
    logic [7:0] i_blue_bot  = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [7:0] o_median_red;
    logic [7:0] o_median_green;
    logic [7:0] o_median_blue;

    rgb_median_3x3_window_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_red_top      (i_red_top),
        .i_red_mid      (i_red_mid),
        .i_red_bot      (i_red_bot),
        .i_green_top    (i_green_top),
        .i_green_mid    (i_green_mid),
        .i_green_bot    (i_green_bot),
        .i_blue_top     (i_blue_top),
        .i_blue_mid     (i_blue_mid),
        .i_blue_bot     (i_blue_bot),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_median_red   (o_median_red),
        .o_median_green (o_median_green),
        .o_median_blue  (o_median_blue)
    );

    // 4 ns period: two ns high, two ns low.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Columns waiting to be offered, and the medians the filter owes us,
    // oldest first.
    t_column col_pending_q[$];
    t_median median_expect_q[$];

    // Our own copy of the two stored columns per channel. Index 0 is red,
    // 1 green, 2 blue; entries 0..2 are the previous column (top, mid, bot)
    // and entries 3..5 the column before it.
    t_pix stored_cols [3][6];

    int mismatches   = 0;
    int cols_sent    = 0;
    int medians_seen = 0;

    // Fifth smallest of nine pixels, found by a plain exchange sort.
    function automatic t_pix fifth_smallest(input t_pix v [9]);
        t_pix s [9];
        t_pix tmp;
        s = v;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8 - i; j++) begin
                if (s[j] > s[j+1]) begin
                    tmp    = s[j];
                    s[j]   = s[j+1];
                    s[j+1] = tmp;
                end
            end
        end
        return s[4];
    endfunction

    // Median of one channel for a new column, then slide that channel's window.
    function automatic t_pix slide_channel(input int ch, input t_pix top,
                                           input t_pix mid, input t_pix bot);
        t_pix cells [9];
        t_pix med;
        cells[0] = top;
        cells[1] = mid;
        cells[2] = bot;
        for (int k = 0; k < 6; k++) begin
            cells[3+k] = stored_cols[ch][k];
        end
        med = fifth_smallest(cells);
        // The previous column ages by one slot and the new one takes its place.
        for (int k = 0; k < 3; k++) begin
            stored_cols[ch][3+k] = stored_cols[ch][k];
        end
        stored_cols[ch][0] = top;
        stored_cols[ch][1] = mid;
        stored_cols[ch][2] = bot;
        return med;
    endfunction

    // One pixel of a random column, drawn the way the column's mix says.
    function automatic t_pix draw_pix(input t_pix_mix mix, input t_pix base);
        int v;
        case (mix)
            MIX_UNIFORM: begin
                v = $urandom_range(0, 255);
            end
            MIX_CLUSTER: begin
                // Values close together make ties and near-ties common.
                v = int'(base) + int'($urandom_range(0, 6)) - 3;
                if (v < 0) begin
                    v = 0;
                end
                if (v > 255) begin
                    v = 255;
                end
            end
            MIX_EXTREME: begin
                v = ($urandom_range(0, 1) == 1) ? 255 : 0;
            end
            default: begin
                v = base;
            end
        endcase
        return t_pix'(v);
    endfunction

    function automatic t_column random_column();
        t_column  c;
        t_pix_mix mix;
        t_pix     base;
        mix  = t_pix_mix'($urandom_range(0, 3));
        // Uniform columns are the most common, the rest stress the sorting.
        if ($urandom_range(0, 3) != 0) begin
            mix = ($urandom_range(0, 1) == 1) ? MIX_UNIFORM : mix;
        end
        base        = t_pix'($urandom_range(0, 255));
        c.red_top   = draw_pix(mix, base);
        c.red_mid   = draw_pix(mix, base);
        c.red_bot   = draw_pix(mix, base);
        c.green_top = draw_pix(mix, base);
        c.green_mid = draw_pix(mix, base);
        c.green_bot = draw_pix(mix, base);
        c.blue_top  = draw_pix(mix, base);
        c.blue_mid  = draw_pix(mix, base);
        c.blue_bot  = draw_pix(mix, base);
        return c;
    endfunction

    // Prints one line per mismatch and keeps the count.
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
                 $realtime, what, got, want, medians_seen);
    endtask

    // Driver. The column on the wire is held until the filter takes it; the
    // expected median is worked out at the edge where the transaction happens.
    t_column col_on_wire = '0;
    int      send_gap    = 0;

    always @(posedge i_clk) begin
        t_median m;
        bit      taken;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            taken = i_valid && o_ready;
            if (taken) begin
                m.red   = slide_channel(0, col_on_wire.red_top,
                                        col_on_wire.red_mid, col_on_wire.red_bot);
                m.green = slide_channel(1, col_on_wire.green_top,
                                        col_on_wire.green_mid, col_on_wire.green_bot);
                m.blue  = slide_channel(2, col_on_wire.blue_top,
                                        col_on_wire.blue_mid, col_on_wire.blue_bot);
                median_expect_q.push_back(m);
                cols_sent++;
            end
            if (!i_valid || taken) begin
                if (send_gap > 0) begin
                    i_valid  <= 1'b0;
                    send_gap--;
                end else if (col_pending_q.size() >= QUIET_TAIL
                             && $urandom_range(0, 9) == 0) begin
                    // Idle burst of random length, starting with this cycle.
                    i_valid  <= 1'b0;
                    send_gap = $urandom_range(0, 13);
                end else if (col_pending_q.size() > 0) begin
                    col_on_wire = col_pending_q.pop_front();
                    i_valid     <= 1'b1;
                    i_red_top   <= col_on_wire.red_top;
                    i_red_mid   <= col_on_wire.red_mid;
                    i_red_bot   <= col_on_wire.red_bot;
                    i_green_top <= col_on_wire.green_top;
                    i_green_mid <= col_on_wire.green_mid;
                    i_green_bot <= col_on_wire.green_bot;
                    i_blue_top  <= col_on_wire.blue_top;
                    i_blue_mid  <= col_on_wire.blue_mid;
                    i_blue_bot  <= col_on_wire.blue_bot;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each median transaction is checked against the oldest
    // expectation. The ready side stalls in random bursts, and once holds off
    // for a long stretch so that both pipeline stages fill and o_ready drops.
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    always @(posedge i_clk) begin
        t_median want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (median_expect_q.size() == 0) begin
                    report_mismatch("unexpected result", o_median_red, -1);
                end else begin
                    want = median_expect_q.pop_front();
                    if (o_median_red !== want.red) begin
                        report_mismatch("median_red", o_median_red, want.red);
                    end
                    if (o_median_green !== want.green) begin
                        report_mismatch("median_green", o_median_green, want.green);
                    end
                    if (o_median_blue !== want.blue) begin
                        report_mismatch("median_blue", o_median_blue, want.blue);
                    end
                end
                medians_seen++;
            end
            if (hold_left > 0) begin
                i_ready   <= 1'b0;
                hold_left--;
            end else if (!hold_done && medians_seen >= HOLD_AT) begin
                i_ready   <= 1'b0;
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
            end else if (stall_left > 0) begin
                i_ready    <= 1'b0;
                stall_left--;
            end else if (col_pending_q.size() >= QUIET_TAIL
                         && $urandom_range(0, 9) == 0) begin
                i_ready    <= 1'b0;
                stall_left = $urandom_range(0, 13);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transaction on either side ends the run.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results still owed",
                         quiet_cycles, median_expect_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 6; k++) begin
                stored_cols[ch][k] = '0;
            end
        end

        // Right after reset the zero columns are part of the window: a full
        // column of 255 first gives 0, a second one gives 255.
        col_pending_q.push_back({9{8'hFF}});
        col_pending_q.push_back({9{8'hFF}});
        col_pending_q.push_back({9{8'h00}});
        col_pending_q.push_back({9{8'h00}});
        // A single field at its maximum, every field in turn.
        for (int k = 0; k < 9; k++) begin
            col_pending_q.push_back(t_column'(72'hFF << (8 * k)));
        end
        col_pending_q.push_back({9{8'h55}});
        col_pending_q.push_back({9{8'hAA}});
        col_pending_q.push_back({8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9});
        col_pending_q.push_back({8'd254, 8'd0, 8'd128, 8'd255, 8'd1, 8'd127,
                                 8'd0, 8'd255, 8'd129});
        col_pending_q.push_back({9{8'd128}});
        col_pending_q.push_back({8'd128, 8'd128, 8'd127, 8'd129, 8'd128, 8'd128,
                                 8'd127, 8'd127, 8'd129});
        col_pending_q.push_back({9{8'hFF}});
        col_pending_q.push_back({9{8'h00}});
        col_pending_q.push_back({9{8'hFF}});

        for (int n = 0; n < RANDOM_COLUMNS; n++) begin
            col_pending_q.push_back(random_column());
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (col_pending_q.size() != 0 || i_valid || median_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d columns and checked %0d RGB medians, with reset zeros,",
                 cols_sent, medians_seen);
        $display("extreme and tied pixels, random stalls and a long output hold-off.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rgbm_pkg.sv
rtl/rgbm_window.sv
rtl/rgbm_median9.sv
rtl/rgb_median_3x3_window_core.sv
tb/rgb_median_3x3_window_core_test.sv
